@@ src/cfsa_pkg.sv @@
// Shared types, constants and the step-angle function for the sky angle converter.
`timescale 1ns / 1ps
package cfsa_pkg;

    localparam int CORDIC_STEPS = 40;
    localparam int SQRT_CELLS   = 32;
    localparam int NORM_CELLS   = 6;

    // Angle unit: 45 degrees is 2^40.
    localparam logic signed [45:0] ANG_ONE = 46'sh100_0000_0000;
    localparam logic [30:0] RA_FULL = 31'd1509949440;
    localparam logic [29:0] DEC_MAX = 30'd377487360;

    localparam logic [2:0] FACE_NORTH   = 3'd0;
    localparam logic [2:0] FACE_EQ_LAST = 3'd4;
    localparam logic [2:0] FACE_SOUTH   = 3'd5;

    // Face point carried alongside the square root.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [2:0]         face;
    } cfsa_side_t;

    // One square root digit cell's state.
    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
        cfsa_side_t  side;
    } cfsa_root_t;

    // A vector under rotation with its accumulated angle.
    typedef struct packed {
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [45:0] z;
    } cfsa_vec_t;

    // Both vectors of one request plus what the final stages need.
    typedef struct packed {
        cfsa_vec_t  ra;
        cfsa_vec_t  dc;
        logic [2:0] face;
        logic       origin;
    } cfsa_pair_t;

    // Unsigned long division by shift and subtract, for elaboration-time constants.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q62 arctangent of 1/n by an alternating series with floor divisions.
    function automatic logic [63:0] atan_recip_q62(logic [63:0] n);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] k;
        logic [63:0] term;
        p   = udiv64(64'd1 << 62, n);
        sum = '0;
        k   = '0;
        while (p != 64'd0)
        begin
            term = udiv64(p, (k << 1) + 64'd1);
            if (k[0] == 1'b0)
                sum = sum + term;
            else
                sum = sum - term;
            p = udiv64(udiv64(p, n), n);
            k = k + 64'd1;
        end
        return sum;
    endfunction

    // Rounded micro-rotation angle atan(2^-idx) in the angle unit.
    function automatic logic signed [45:0] step_angle(int idx);
        logic [63:0] quarter_pi;
        logic [63:0] r;
        logic [63:0] v;
        if (idx == 0)
            return ANG_ONE;
        quarter_pi = (atan_recip_q62(64'd5) << 2) - atan_recip_q62(64'd239);
        r = atan_recip_q62(64'd1 << idx);
        v = '0;
        for (int b = 0; b < 41; b++)
        begin
            r = r << 1;
            v = v << 1;
            if (r >= quarter_pi)
            begin
                r = r - quarter_pi;
                v = v | 64'd1;
            end
        end
        return 46'((v + 64'd1) >> 1);
    endfunction

endpackage

@@ src/cfsa_if.sv @@
// Valid/ready channel interfaces for face points and sky angles.
`timescale 1ns / 1ps
interface cfsa_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [2:0]         face;

    modport source (output valid, x_coord, y_coord, face, input ready);
    modport sink (input valid, x_coord, y_coord, face, output ready);
endinterface

interface cfsa_angles_if;
    logic               valid;
    logic               ready;
    logic [30:0]        right_ascension;
    logic signed [29:0] declination;

    modport source (output valid, right_ascension, declination, input ready);
    modport sink (input valid, right_ascension, declination, output ready);
endinterface

@@ src/cfsa_sqrt_cell.sv @@
// One digit cell of the square root chain: two radicand bits in, one root bit out.
`timescale 1ns / 1ps
module cfsa_sqrt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  cfsa_pkg::cfsa_root_t in_d,
    output logic               out_valid,
    output cfsa_pkg::cfsa_root_t out_d
);
    import cfsa_pkg::*;

    logic [34:0] rem2;
    logic [34:0] trial;
    cfsa_root_t  d_next;

    // Restoring digit step.
    always_comb
    begin
        rem2  = {in_d.rem[32:0], in_d.rad[63:62]};
        trial = {1'b0, in_d.root, 2'b01};
        d_next.rad  = {in_d.rad[61:0], 2'b00};
        d_next.side = in_d.side;
        if (rem2 >= trial)
        begin
            d_next.rem  = rem2 - trial;
            d_next.root = {in_d.root[30:0], 1'b1};
        end
        else
        begin
            d_next.rem  = rem2;
            d_next.root = {in_d.root[30:0], 1'b0};
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
            out_d <= d_next;
    end
endmodule

@@ src/cfsa_norm_cell.sv @@
// One normalising cell: shifts each vector left when its larger component is small.
`timescale 1ns / 1ps
module cfsa_norm_cell #(
    parameter int SHIFT = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  cfsa_pkg::cfsa_pair_t in_d,
    output logic               out_valid,
    output cfsa_pkg::cfsa_pair_t out_d
);
    import cfsa_pkg::*;

    localparam logic signed [63:0] LIMIT = 64'sd1 <<< (58 - SHIFT);

    cfsa_pair_t d_next;

    function automatic cfsa_vec_t norm(cfsa_vec_t v);
        logic signed [63:0] ay;
        logic signed [63:0] mx;
        cfsa_vec_t          r;
        ay = (v.vy < 0) ? -v.vy : v.vy;
        mx = (v.vx > ay) ? v.vx : ay;
        r  = v;
        if (mx < LIMIT)
        begin
            r.vx = v.vx <<< SHIFT;
            r.vy = v.vy <<< SHIFT;
        end
        return r;
    endfunction

    // Both lanes normalise independently.
    always_comb
    begin
        d_next    = in_d;
        d_next.ra = norm(in_d.ra);
        d_next.dc = norm(in_d.dc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_d <= d_next;
    end
endmodule

@@ src/cfsa_cordic_cell.sv @@
// One vectoring CORDIC cell working on both lanes with a fixed step index.
`timescale 1ns / 1ps
module cfsa_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  cfsa_pkg::cfsa_pair_t in_d,
    output logic               out_valid,
    output cfsa_pkg::cfsa_pair_t out_d
);
    import cfsa_pkg::*;

    localparam logic signed [45:0] ANG = step_angle(IDX);

    cfsa_pair_t d_next;

    // Rotate towards the x axis; shifts round towards minus infinity.
    function automatic cfsa_vec_t rotate(cfsa_vec_t v);
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        cfsa_vec_t          r;
        dx = v.vy >>> IDX;
        dy = v.vx >>> IDX;
        if (v.vy >= 0)
        begin
            r.vx = v.vx + dx;
            r.vy = v.vy - dy;
            r.z  = v.z + ANG;
        end
        else
        begin
            r.vx = v.vx - dx;
            r.vy = v.vy + dy;
            r.z  = v.z - ANG;
        end
        return r;
    endfunction

    always_comb
    begin
        d_next    = in_d;
        d_next.ra = rotate(in_d.ra);
        d_next.dc = rotate(in_d.dc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_d <= d_next;
    end
endmodule

@@ src/cube_face_xy_to_sky_angles.sv @@
// Top level: cube face point to right ascension and declination, fully pipelined.
// Accepts one point per clock while ready is high and returns one result per point in
// order, through a chain of 85 register stages: three input stages, 32 square root
// digit cells, one vector set-up stage, six normalising cells, 40 CORDIC cells (both
// angle vectors side by side), two scaling stages and the output register.
// A skid register behind the output lets the chain run while a finished result waits;
// ready drops only when both are full.
`timescale 1ns / 1ps
module cube_face_xy_to_sky_angles (
    input  logic            clk,
    input  logic            rst_n,
    cfsa_point_if.sink      point,
    cfsa_angles_if.source   angles
);
    import cfsa_pkg::*;

    logic en;

    // Input and square stages.
    logic               s0_v_reg;
    cfsa_side_t         s0_reg;
    logic               s1_v_reg;
    cfsa_side_t         s1_reg;
    logic [63:0]        sqx_reg;
    logic [63:0]        sqy_reg;
    logic [31:0]        ux;
    logic [31:0]        uy;
    logic               s1_equ;
    logic [63:0]        rad_next;

    // Chains.
    logic               root_v [SQRT_CELLS+1];
    cfsa_root_t         root_d [SQRT_CELLS+1];
    logic               norm_v [NORM_CELLS+1];
    cfsa_pair_t         norm_d [NORM_CELLS+1];
    logic               cord_v [CORDIC_STEPS+1];
    cfsa_pair_t         cord_d [CORDIC_STEPS+1];
    cfsa_pair_t         prep_next;

    // Scaling stages.
    logic               p1_v_reg;
    logic [43:0]        ra_pos_reg;
    logic [41:0]        dec_mag_reg;
    logic               dec_neg_reg;
    logic               p2_v_reg;
    logic [31:0]        ra_o_reg;
    logic [29:0]        dec_o_reg;
    logic               dec_neg2_reg;
    logic [43:0]        ra_pos_next;
    logic [41:0]        dec_mag_next;
    logic               dec_neg_next;
    logic [30:0]        ra_fin;
    logic [29:0]        dec_fin;

    // Output register and skid.
    logic               out_v_reg;
    logic [30:0]        out_ra_reg;
    logic [29:0]        out_dec_reg;
    logic               skid_v_reg;
    logic [30:0]        skid_ra_reg;
    logic [29:0]        skid_dec_reg;

    assign en          = ~skid_v_reg;
    assign point.ready = en;

    // Absolute values and radicand selection.
    always_comb
    begin
        ux       = s0_reg.x[31] ? 32'(-s0_reg.x) : 32'(s0_reg.x);
        uy       = s0_reg.y[31] ? 32'(-s0_reg.y) : 32'(s0_reg.y);
        s1_equ   = (s1_reg.face != FACE_NORTH) && (s1_reg.face <= FACE_EQ_LAST);
        rad_next = s1_equ ? (64'd1 << 60) + sqx_reg : sqx_reg + sqy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            root_v[0] <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg  <= point.valid;
            s1_v_reg  <= s0_v_reg;
            root_v[0] <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg.x    <= point.x_coord;
            s0_reg.y    <= point.y_coord;
            s0_reg.face <= point.face;
            s1_reg      <= s0_reg;
            sqx_reg     <= ux * ux;
            sqy_reg     <= uy * uy;
            root_d[0].rad  <= rad_next;
            root_d[0].rem  <= '0;
            root_d[0].root <= '0;
            root_d[0].side <= s1_reg;
        end
    end

    // Square root digit chain.
    for (genvar k = 0; k < SQRT_CELLS; k++)
    begin : g_sqrt
        cfsa_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (root_v[k]),
            .in_d      (root_d[k]),
            .out_valid (root_v[k+1]),
            .out_d     (root_d[k+1])
        );
    end

    // Vector set-up: pick each lane's vector and fold the left half plane.
    function automatic cfsa_vec_t fold(logic signed [63:0] vx, logic signed [63:0] vy);
        cfsa_vec_t r;
        if (vx < 0)
        begin
            r.vx = -vx;
            r.vy = -vy;
            r.z  = ANG_ONE <<< 2;
        end
        else
        begin
            r.vx = vx;
            r.vy = vy;
            r.z  = '0;
        end
        return r;
    endfunction

    always_comb
    begin
        cfsa_side_t         s;
        logic               equ;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic signed [63:0] one;
        logic signed [63:0] rt;
        s   = root_d[SQRT_CELLS].side;
        equ = (s.face != FACE_NORTH) && (s.face <= FACE_EQ_LAST);
        xs  = 64'(s.x);
        ys  = 64'(s.y);
        one = 64'sd1 <<< 30;
        rt  = $signed({32'd0, root_d[SQRT_CELLS].root});
        if (equ)
        begin
            prep_next.ra = fold(one, xs);
            prep_next.dc = fold(rt, ys);
        end
        else if (s.face == FACE_NORTH)
        begin
            prep_next.ra = fold(-ys, xs);
            prep_next.dc = fold(rt, one);
        end
        else
        begin
            prep_next.ra = fold(ys, xs);
            prep_next.dc = fold(rt, one);
        end
        prep_next.face   = s.face;
        prep_next.origin = (s.x == 32'sd0) && (s.y == 32'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            norm_v[0] <= 1'b0;
        else if (en)
            norm_v[0] <= root_v[SQRT_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            norm_d[0] <= prep_next;
    end

    // Normalising chain, shifts of 32, 16, 8, 4, 2 and 1.
    for (genvar k = 0; k < NORM_CELLS; k++)
    begin : g_norm
        cfsa_norm_cell #(.SHIFT(32 >> k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (norm_v[k]),
            .in_d      (norm_d[k]),
            .out_valid (norm_v[k+1]),
            .out_d     (norm_d[k+1])
        );
    end

    assign cord_v[0] = norm_v[NORM_CELLS];
    assign cord_d[0] = norm_d[NORM_CELLS];

    // CORDIC chain.
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        cfsa_cordic_cell #(.IDX(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cord_v[k]),
            .in_d      (cord_d[k]),
            .out_valid (cord_v[k+1]),
            .out_d     (cord_d[k+1])
        );
    end

    // Face offset, special cases and sign handling.
    always_comb
    begin
        cfsa_pair_t         c;
        logic               equ;
        logic               polar;
        logic signed [46:0] ra_a;
        logic signed [46:0] dec_a;
        c     = cord_d[CORDIC_STEPS];
        equ   = (c.face != FACE_NORTH) && (c.face <= FACE_EQ_LAST);
        polar = (c.face == FACE_NORTH) || (c.face == FACE_SOUTH);
        if (polar && c.origin)
        begin
            ra_a  = (c.face == FACE_NORTH) ? 47'(ANG_ONE) <<< 2 : 47'sd0;
            dec_a = 47'(ANG_ONE) <<< 1;
        end
        else
        begin
            ra_a  = 47'(c.ra.z);
            if (equ)
                ra_a = ra_a + ($signed({44'd0, 3'(c.face - 3'd1)}) <<< 41);
            dec_a = 47'(c.dc.z);
        end
        if (c.face == FACE_SOUTH)
            dec_a = -dec_a;
        if (ra_a < 0)
            ra_a = ra_a + (47'sd1 <<< 43);
        if (ra_a < 0)
            ra_a = '0;
        if (equ || polar)
        begin
            ra_pos_next  = ra_a[43:0];
            dec_neg_next = dec_a[46];
            dec_mag_next = dec_a[46] ? 42'(-dec_a) : dec_a[41:0];
        end
        else
        begin
            ra_pos_next  = '0;
            dec_neg_next = 1'b0;
            dec_mag_next = '0;
        end
    end

    // Final wrap and saturation.
    always_comb
    begin
        logic [29:0] dsat;
        ra_fin  = (ra_o_reg >= {1'b0, RA_FULL}) ? 31'(ra_o_reg - {1'b0, RA_FULL})
                                               : ra_o_reg[30:0];
        dsat    = (dec_o_reg > DEC_MAX) ? DEC_MAX : dec_o_reg;
        dec_fin = dec_neg2_reg ? 30'(-dsat) : dsat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= cord_v[CORDIC_STEPS];
            p2_v_reg <= p1_v_reg;
        end
    end

    // Scaling to 2^-22 degree, rounded.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ra_pos_reg   <= ra_pos_next;
            dec_mag_reg  <= dec_mag_next;
            dec_neg_reg  <= dec_neg_next;
            ra_o_reg     <= 32'(((50'(ra_pos_reg) * 50'd45) + (50'd1 << 17)) >> 18);
            dec_o_reg    <= 30'(((48'(dec_mag_reg) * 48'd45) + (48'd1 << 17)) >> 18);
            dec_neg2_reg <= dec_neg_reg;
        end
    end

    // Output register with skid stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (angles.ready || !out_v_reg)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= en && p2_v_reg;
        end
        else if (en && p2_v_reg)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (angles.ready || !out_v_reg)
        begin
            if (skid_v_reg)
            begin
                out_ra_reg  <= skid_ra_reg;
                out_dec_reg <= skid_dec_reg;
            end
            else
            begin
                out_ra_reg  <= ra_fin;
                out_dec_reg <= dec_fin;
            end
        end
        else if (en && p2_v_reg)
        begin
            skid_ra_reg  <= ra_fin;
            skid_dec_reg <= dec_fin;
        end
    end

    assign angles.valid           = out_v_reg;
    assign angles.right_ascension = out_ra_reg;
    assign angles.declination     = $signed(out_dec_reg);
endmodule

@@ src/cfsa_checker.sv @@
// Port-level checks on the sky angle converter, bound to its top level.
`timescale 1ns / 1ps
module cfsa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [30:0]        out_ra,
    input logic signed [29:0] out_dec
);
    import cfsa_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");

    // Back-pressure only arises behind a waiting result.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // Right ascension stays below a full circle.
    a_ra_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_ra < RA_FULL)
        else $error("right ascension out of range");

    // Declination stays within the poles.
    a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_dec <= $signed(DEC_MAX)) && (out_dec >= -$signed(DEC_MAX)))
        else $error("declination out of range");
endmodule

bind cube_face_xy_to_sky_angles cfsa_checker u_cfsa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (point.ready),
    .out_valid (angles.valid),
    .out_ready (angles.ready),
    .out_ra    (angles.right_ascension),
    .out_dec   (angles.declination)
);

@@ tb/tb_cube_face_xy_to_sky_angles.sv @@
// Self-checking testbench for the cube face point to sky angles converter.
`timescale 1ns / 1ps
module tb_cube_face_xy_to_sky_angles;
    import cfsa_pkg::*;

    localparam int  ITEMS_RANDOM = 1400;
    localparam int  CALM_ITEMS   = 200;
    localparam int  DRAIN_CYCLES = 200;
    localparam int  STALL_LIMIT  = 4000;
    localparam logic [2:0] FACE_BAD_FIRST = 3'd6;
    localparam logic [2:0] FACE_BAD_LAST  = 3'd7;
    localparam logic signed [31:0] Q_ONE  = 32'sh4000_0000;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX  = 32'sh7fff_ffff;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [2:0]         face;
    } face_point_t;

    typedef struct {
        logic [30:0]        ra;
        logic signed [29:0] dec;
    } sky_angles_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cfsa_point_if  point ();
    cfsa_angles_if angles ();

    cube_face_xy_to_sky_angles dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point.sink),
        .angles (angles.source)
    );

    always #1 clk = ~clk;

    face_point_t pending_points[$];
    sky_angles_t awaited_angles[$];
    longint      micro_angle[CORDIC_STEPS];
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_polar = 0;
    int          n_invalid = 0;
    int          idle_cycles = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          stimulus_done = 1'b0;

    // Q62 arctangent of 1/n by an alternating series with floor divisions.
    function automatic longint unsigned atan_inv_q62(longint unsigned n);
        longint unsigned p, sum, k, term;
        p = (64'd1 << 62) / n;
        sum = 0;
        k = 0;
        while (p != 0)
        begin
            term = p / (2 * k + 1);
            if (k[0] == 1'b0)
                sum = sum + term;
            else
                sum = sum - term;
            p = p / n / n;
            k++;
        end
        return sum;
    endfunction

    // Micro-rotation angles in the unit where 45 degrees is 2^40.
    function automatic void build_micro_angles();
        longint unsigned quarter_pi, r, v;
        quarter_pi = 4 * atan_inv_q62(5) - atan_inv_q62(239);
        micro_angle[0] = longint'(ANG_ONE);
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            r = atan_inv_q62(64'd1 << i);
            v = 0;
            for (int b = 0; b < 41; b++)
            begin
                r = r << 1;
                v = v << 1;
                if (r >= quarter_pi)
                begin
                    r = r - quarter_pi;
                    v = v | 64'd1;
                end
            end
            micro_angle[i] = longint'((v + 1) >> 1);
        end
    endfunction

    // Angle of the vector (vx, vy) by vectoring CORDIC.
    function automatic longint vector_angle(longint vx, longint vy);
        longint base, z, ay, mx, dx, dy;
        base = 0;
        z = 0;
        if (vx == 0 && vy == 0)
            return 0;
        if (vx < 0)
        begin
            vx = -vx;
            vy = -vy;
            base = 4 * longint'(ANG_ONE);
        end
        ay = (vy < 0) ? -vy : vy;
        mx = (vx > ay) ? vx : ay;
        while (mx < (64'sd1 <<< 57))
        begin
            vx = vx * 2;
            vy = vy * 2;
            mx = mx * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx = vx + dx;
                vy = vy - dy;
                z = z + micro_angle[i];
            end
            else
            begin
                vx = vx - dx;
                vy = vy + dy;
                z = z - micro_angle[i];
            end
        end
        return base + z;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res, bitpos;
        res = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > n)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (n >= res + bitpos)
            begin
                n = n - (res + bitpos);
                res = (res >> 1) + bitpos;
            end
            else
                res = res >> 1;
            bitpos = bitpos >> 2;
        end
        return res;
    endfunction

    // Angle to 2^-22 degree units; ra wraps into [0, 360).
    function automatic logic [30:0] ra_to_units(longint a);
        longint unsigned o;
        if (a < 0)
            a = a + 8 * longint'(ANG_ONE);
        if (a < 0)
            a = 0;
        o = (longint'(a) * 45 + (64'd1 << 17)) >> 18;
        while (o >= RA_FULL)
            o = o - RA_FULL;
        return o[30:0];
    endfunction

    // Signed angle to 2^-22 degree units, half away from zero, saturated at 90.
    function automatic logic signed [29:0] dec_to_units(longint a);
        longint unsigned m, o;
        m = (a < 0) ? longint'(-a) : longint'(a);
        o = (m * 45 + (64'd1 << 17)) >> 18;
        if (o > DEC_MAX)
            o = DEC_MAX;
        if (a < 0)
            o = 64'd0 - o;
        return o[29:0];
    endfunction

    function automatic sky_angles_t predict_angles(face_point_t p);
        sky_angles_t     res;
        longint          x, y, ra_a, dec_a;
        longint unsigned ux, uy, r;
        x = p.x;
        y = p.y;
        ux = (x < 0) ? -x : x;
        uy = (y < 0) ? -y : y;
        res.ra = '0;
        res.dec = '0;
        if (p.face > FACE_NORTH && p.face <= FACE_EQ_LAST)
        begin
            ra_a = vector_angle(longint'(Q_ONE), x)
                 + longint'(p.face - 1) * 2 * longint'(ANG_ONE);
            r = floor_sqrt((64'd1 << 60) + ux * ux);
            dec_a = vector_angle(longint'(r), y);
            res.ra = ra_to_units(ra_a);
            res.dec = dec_to_units(dec_a);
        end
        else if (p.face == FACE_NORTH || p.face == FACE_SOUTH)
        begin
            if (x == 0 && y == 0)
            begin
                ra_a = (p.face == FACE_NORTH) ? 4 * longint'(ANG_ONE) : 0;
                dec_a = 2 * longint'(ANG_ONE);
            end
            else
            begin
                r = floor_sqrt(ux * ux + uy * uy);
                ra_a = (p.face == FACE_NORTH) ? vector_angle(-y, x) : vector_angle(y, x);
                dec_a = vector_angle(longint'(r), longint'(Q_ONE));
            end
            if (p.face == FACE_SOUTH)
                dec_a = -dec_a;
            res.ra = ra_to_units(ra_a);
            res.dec = dec_to_units(dec_a);
        end
        return res;
    endfunction

    function automatic logic signed [31:0] random_coord();
        // Mostly the face proper, sometimes the whole Q2.30 range.
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 2 * 32'h4000_0000)) - Q_ONE;
    endfunction

    task automatic queue_point(logic signed [31:0] x, logic signed [31:0] y,
                               logic [2:0] face);
        face_point_t p;
        p.x = x;
        p.y = y;
        p.face = face;
        pending_points.push_back(p);
    endtask

    // Request driver: takes points from the pending queue, with idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point.valid <= 1'b0;
            point.x_coord <= '0;
            point.y_coord <= '0;
            point.face <= FACE_NORTH;
            gap_left <= 0;
        end
        else
        begin
            if (point.valid && point.ready)
            begin
                face_point_t p;
                p.x = point.x_coord;
                p.y = point.y_coord;
                p.face = point.face;
                awaited_angles.push_back(predict_angles(p));
                n_sent++;
                if (p.face == FACE_NORTH || p.face == FACE_SOUTH)
                    n_polar++;
                if (p.face == FACE_BAD_FIRST || p.face == FACE_BAD_LAST)
                    n_invalid++;
            end
            if (!point.valid || point.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    point.valid <= 1'b0;
                end
                else if (pending_points.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
                begin
                    gap_left <= $urandom_range(0, 7);
                    point.valid <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    face_point_t p;
                    p = pending_points.pop_front();
                    point.x_coord <= p.x;
                    point.y_coord <= p.y;
                    point.face <= p.face;
                    point.valid <= 1'b1;
                end
                else
                    point.valid <= 1'b0;
            end
        end
    end

    // Result monitor: random back-pressure and in-order comparison.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angles.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (angles.valid && angles.ready)
            begin
                sky_angles_t want;
                if (awaited_angles.size() == 0)
                begin
                    $error("unexpected result: ra %0d dec %0d",
                           angles.right_ascension, angles.declination);
                    errors++;
                end
                else
                begin
                    want = awaited_angles.pop_front();
                    n_checked++;
                    if (angles.right_ascension !== want.ra)
                    begin
                        $error("right_ascension: expected %0d, got %0d",
                               want.ra, angles.right_ascension);
                        errors++;
                    end
                    if (angles.declination !== want.dec)
                    begin
                        $error("declination: expected %0d, got %0d",
                               want.dec, angles.declination);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                angles.ready <= 1'b0;
            end
            else if (pending_points.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 7);
                angles.ready <= 1'b0;
            end
            else
                angles.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no request or result moving.
    always @(posedge clk)
    begin
        if (rst_n && !stimulus_done)
        begin
            if ((point.valid && point.ready) || (angles.valid && angles.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("** cube_face_xy_to_sky_angles: FAILED **");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int waited;
        build_micro_angles();

        // Directed points: corners, origins, range extremes, every face.
        for (int f = 0; f < 8; f++)
        begin
            queue_point(Q_ONE, -Q_ONE, 3'(f));
            queue_point(-Q_ONE, Q_ONE, 3'(f));
        end
        queue_point('0, '0, FACE_NORTH);
        queue_point('0, '0, FACE_SOUTH);
        queue_point(Q_MIN, Q_MAX, FACE_NORTH);
        queue_point(Q_MAX, Q_MIN, FACE_SOUTH);
        queue_point(Q_MIN, Q_MIN, 3'd1);
        queue_point(Q_MAX, Q_MAX, FACE_EQ_LAST);
        queue_point(-32'sd1, '0, 3'd1);
        queue_point('0, 32'sd1, FACE_SOUTH);

        for (int i = 0; i < ITEMS_RANDOM; i++)
        begin
            logic signed [31:0] x, y;
            x = random_coord();
            y = random_coord();
            // Now and then the origin or a point on an axis.
            case ($urandom_range(0, 19))
                0: begin x = '0; y = '0; end
                1: x = '0;
                2: y = '0;
                default: ;
            endcase
            queue_point(x, y, 3'($urandom_range(0, 7)));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_points.size() > 0 || point.valid)
            @(posedge clk);
        waited = 0;
        while (awaited_angles.size() > 0 && waited < 20 * STALL_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        stimulus_done = 1'b1;
        if (awaited_angles.size() > 0)
        begin
            $display("timeout: %0d results never arrived", awaited_angles.size());
            $display("** cube_face_xy_to_sky_angles: FAILED **");
            $finish;
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            $display("Converted %0d points (%0d on polar caps, %0d on invalid faces),",
                     n_sent, n_polar, n_invalid);
            $display("checked %0d results under random idling and back-pressure.",
                     n_checked);
            if (errors == 0)
                $display("** cube_face_xy_to_sky_angles: PASSED **");
            else
                $display("** cube_face_xy_to_sky_angles: FAILED **");
            $finish;
        end
    end

endmodule
